[rtl/sfl_pkg.sv]
// Shared types, widths and codes for the sky-box face and texel lookup.
`default_nettype none

package sfl_pkg;

  localparam int COORD_BITS = 24;
  localparam int TEX_BITS   = 12;
  localparam int SIZE_BITS  = 13;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int NUM_BITS   = COORD_BITS + 1;
  localparam int WIDE_BITS  = COORD_BITS + 2;
  localparam int QUOT_BITS  = SIZE_BITS;
  localparam int PROD_BITS  = NUM_BITS + SIZE_BITS;
  localparam int CAP_BITS   = (SIZE_BITS > TEX_BITS + 1) ? SIZE_BITS : TEX_BITS + 1;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [2:0] FACE_FRONT = 3'd0;
  localparam logic [2:0] FACE_LEFT  = 3'd1;
  localparam logic [2:0] FACE_BACK  = 3'd2;
  localparam logic [2:0] FACE_RIGHT = 3'd3;
  localparam logic [2:0] FACE_TOP   = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SKY_ENABLED = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TEX_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TEX_HEIGHT  = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [2:0]          face;
    logic [TEX_BITS-1:0] texel_x;
    logic [TEX_BITS-1:0] texel_y;
  } out_item_t;

  // Face decision and the two ratios still to be divided
  typedef struct packed {
    logic                hit;
    logic [2:0]          face;
    logic [NUM_BITS-1:0] num_x;
    logic [NUM_BITS-1:0] num_y;
    logic [NUM_BITS-1:0] den_x;
    logic [NUM_BITS-1:0] den_y;
  } sel_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] face;
  } tag_t;

  typedef struct packed {
    tag_t                 tag;
    logic [QUOT_BITS-1:0] quot_x;
    logic [QUOT_BITS-1:0] quot_y;
  } quot_t;

endpackage

`default_nettype wire

[rtl/sfl_face_sel.sv]
// Two-stage face selection: clamp and magnitudes, then face test and ratio setup.
`default_nettype none

module sfl_face_sel (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire sfl_pkg::in_item_t in_item,
  output logic                   ready,
  input  wire logic              sky_enabled,
  output logic                   out_valid,
  output sfl_pkg::sel_t          out_data,
  input  wire logic              down_ready
);

  typedef struct packed {
    logic [sfl_pkg::MAG_BITS-1:0]          y;
    logic [sfl_pkg::MAG_BITS-1:0]          ax;
    logic [sfl_pkg::MAG_BITS-1:0]          az;
    logic signed [sfl_pkg::COORD_BITS-1:0] x;
    logic signed [sfl_pkg::COORD_BITS-1:0] z;
  } pre_t;

  logic  v1;
  pre_t  pre;
  pre_t  pre_next;
  logic  r1;
  logic  r2;
  sfl_pkg::sel_t sel_next;

  logic signed [sfl_pkg::WIDE_BITS-1:0] wx;
  logic signed [sfl_pkg::WIDE_BITS-1:0] wy;
  logic signed [sfl_pkg::WIDE_BITS-1:0] wz;
  logic signed [sfl_pkg::WIDE_BITS-1:0] wax;
  logic signed [sfl_pkg::WIDE_BITS-1:0] waz;
  logic signed [sfl_pkg::WIDE_BITS-1:0] nx;
  logic signed [sfl_pkg::WIDE_BITS-1:0] ny;
  logic [sfl_pkg::MAG_BITS-1:0]         m;
  logic                                 half_y;
  logic                                 z_neg;
  logic                                 z_pos;
  logic                                 x_neg;
  logic                                 x_pos;

  assign r2    = !out_valid || down_ready;
  assign r1    = !v1 || r2;
  assign ready = r1;

  // Stage 1: clamp y, take magnitudes
  always_comb begin
    pre_next.x  = in_item.pos_x;
    pre_next.z  = in_item.pos_z;
    pre_next.y  = in_item.pos_y[sfl_pkg::COORD_BITS-1] ? '0 :
                  sfl_pkg::MAG_BITS'(in_item.pos_y);
    pre_next.ax = in_item.pos_x[sfl_pkg::COORD_BITS-1] ?
                  sfl_pkg::MAG_BITS'(-in_item.pos_x) : sfl_pkg::MAG_BITS'(in_item.pos_x);
    pre_next.az = in_item.pos_z[sfl_pkg::COORD_BITS-1] ?
                  sfl_pkg::MAG_BITS'(-in_item.pos_z) : sfl_pkg::MAG_BITS'(in_item.pos_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
    if (r1 && in_valid) begin
      pre <= pre_next;
    end
  end

  // Stage 2: first face in priority order, numerators and denominators
  always_comb begin
    wx  = {{2{pre.x[sfl_pkg::COORD_BITS-1]}}, pre.x};
    wz  = {{2{pre.z[sfl_pkg::COORD_BITS-1]}}, pre.z};
    wy  = {2'b00, pre.y};
    wax = {2'b00, pre.ax};
    waz = {2'b00, pre.az};
    z_neg = pre.z[sfl_pkg::COORD_BITS-1];
    z_pos = !z_neg && (pre.z != '0);
    x_neg = pre.x[sfl_pkg::COORD_BITS-1];
    x_pos = !x_neg && (pre.x != '0);
    nx = '0;
    ny = '0;
    m  = '0;
    half_y = 1'b0;
    sel_next.hit  = 1'b0;
    sel_next.face = sfl_pkg::FACE_FRONT;
    if (!sky_enabled) begin
      sel_next.hit = 1'b0;
    end else if (pre.y != '0 && pre.ax <= pre.y && pre.az <= pre.y) begin
      sel_next.hit = 1'b1; sel_next.face = sfl_pkg::FACE_TOP;
      m = pre.y; nx = wy - wx; ny = wy + wz; half_y = 1'b1;
    end else if (z_neg && pre.ax <= pre.az && pre.y <= pre.az) begin
      sel_next.hit = 1'b1; sel_next.face = sfl_pkg::FACE_FRONT;
      m = pre.az; nx = waz + wx; ny = waz - wy;
    end else if (z_pos && pre.ax <= pre.az && pre.y <= pre.az) begin
      sel_next.hit = 1'b1; sel_next.face = sfl_pkg::FACE_BACK;
      m = pre.az; nx = waz - wx; ny = waz - wy;
    end else if (x_pos && pre.az <= pre.ax && pre.y <= pre.ax) begin
      sel_next.hit = 1'b1; sel_next.face = sfl_pkg::FACE_LEFT;
      m = pre.ax; nx = wax + wz; ny = wax - wy;
    end else if (x_neg && pre.az <= pre.ax && pre.y <= pre.ax) begin
      sel_next.hit = 1'b1; sel_next.face = sfl_pkg::FACE_RIGHT;
      m = pre.ax; nx = wax - wz; ny = wax - wy;
    end
    sel_next.num_x = nx[sfl_pkg::NUM_BITS-1:0];
    sel_next.num_y = ny[sfl_pkg::NUM_BITS-1:0];
    if (sel_next.hit) begin
      sel_next.den_x = {m, 1'b0};
      sel_next.den_y = half_y ? {m, 1'b0} : {1'b0, m};
    end else begin
      sel_next.den_x = sfl_pkg::NUM_BITS'(1);
      sel_next.den_y = sfl_pkg::NUM_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r2) begin
      out_valid <= v1;
    end
    if (r2 && v1) begin
      out_data <= sel_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sfl_div.sv]
// Scale-and-divide pipeline: one multiply stage, then one restoring quotient bit per stage.
`default_nettype none

module sfl_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire sfl_pkg::sel_t                   in_data,
  output logic                                 ready,
  input  wire logic [sfl_pkg::SIZE_BITS-1:0]   tex_width,
  input  wire logic [sfl_pkg::SIZE_BITS-1:0]   tex_height,
  output logic                                 out_valid,
  output sfl_pkg::quot_t                       out_data,
  input  wire logic                            down_ready
);

  localparam int QB = sfl_pkg::QUOT_BITS;
  localparam int NB = sfl_pkg::NUM_BITS;
  localparam int PB = sfl_pkg::PROD_BITS;

  logic                 st_v  [0:QB];
  logic                 rdy   [0:QB];
  logic [NB-1:0]        rem_x [0:QB];
  logic [NB-1:0]        rem_y [0:QB];
  logic [NB-1:0]        d_x   [0:QB];
  logic [NB-1:0]        d_y   [0:QB];
  logic [QB-1:0]        low_x [0:QB];
  logic [QB-1:0]        low_y [0:QB];
  logic [QB-1:0]        q_x   [0:QB];
  logic [QB-1:0]        q_y   [0:QB];
  sfl_pkg::tag_t        tag   [0:QB];
  logic [PB-1:0]        prod_x;
  logic [PB-1:0]        prod_y;

  assign ready = rdy[0];
  assign rdy[0] = !st_v[0] || rdy[1];

  // Product over 2^QB stays below the divisor, so it seeds the remainder
  assign prod_x = PB'(tex_width) * PB'(in_data.num_x);
  assign prod_y = PB'(tex_height) * PB'(in_data.num_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (rdy[0]) begin
      st_v[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      rem_x[0]    <= prod_x[PB-1:QB];
      rem_y[0]    <= prod_y[PB-1:QB];
      low_x[0]    <= prod_x[QB-1:0];
      low_y[0]    <= prod_y[QB-1:0];
      d_x[0]      <= in_data.den_x;
      d_y[0]      <= in_data.den_y;
      q_x[0]      <= '0;
      q_y[0]      <= '0;
      tag[0].hit  <= in_data.hit;
      tag[0].face <= in_data.face;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [NB:0] tx;
    logic [NB:0] ty;
    logic        gex;
    logic        gey;

    if (k == QB) begin : g_last
      assign rdy[k] = !st_v[k] || down_ready;
    end else begin : g_mid
      assign rdy[k] = !st_v[k] || rdy[k+1];
    end

    always_comb begin
      tx  = {rem_x[k-1], low_x[k-1][QB-k]};
      ty  = {rem_y[k-1], low_y[k-1][QB-k]};
      gex = tx >= {1'b0, d_x[k-1]};
      gey = ty >= {1'b0, d_y[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else if (rdy[k]) begin
        st_v[k] <= st_v[k-1];
      end
      if (rdy[k] && st_v[k-1]) begin
        rem_x[k] <= gex ? NB'(tx - {1'b0, d_x[k-1]}) : tx[NB-1:0];
        rem_y[k] <= gey ? NB'(ty - {1'b0, d_y[k-1]}) : ty[NB-1:0];
        q_x[k]   <= {q_x[k-1][QB-2:0], gex};
        q_y[k]   <= {q_y[k-1][QB-2:0], gey};
        low_x[k] <= low_x[k-1];
        low_y[k] <= low_y[k-1];
        d_x[k]   <= d_x[k-1];
        d_y[k]   <= d_y[k-1];
        tag[k]   <= tag[k-1];
      end
    end
  end

  assign out_valid       = st_v[QB];
  assign out_data.tag    = tag[QB];
  assign out_data.quot_x = q_x[QB];
  assign out_data.quot_y = q_y[QB];

endmodule

`default_nettype wire

[rtl/skybox_face_texel_lookup_core.sv]
// Top level: configuration registers, face select, divide pipeline and saturating output stage.
// Pipeline: 2 face select stages, 1 multiply stage, 13 quotient steps and 1 output
// register between an accepted item and its result.
// Throughput: one item per cycle while out_stall is low, set by the per-bit restoring divider pipeline;
// bubbles collapse stage by stage while the output is stalled.
// Reset: sky enabled, texture 256 x 256, all pipeline valid bits cleared.
`default_nettype none

module skybox_face_texel_lookup_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire sfl_pkg::in_item_t                   in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output sfl_pkg::out_item_t                       out_item,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sfl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [sfl_pkg::SIZE_BITS-1:0]       cfg_data
);

  localparam logic [sfl_pkg::CAP_BITS-1:0] TEX_LIMIT =
    sfl_pkg::CAP_BITS'(1) << sfl_pkg::TEX_BITS;

  logic                          sky_enabled;
  logic [sfl_pkg::SIZE_BITS-1:0] tex_width;
  logic [sfl_pkg::SIZE_BITS-1:0] tex_height;

  logic                 fs_ready;
  logic                 fs_valid;
  sfl_pkg::sel_t        fs_data;
  logic                 div_ready;
  logic                 div_valid;
  sfl_pkg::quot_t       div_data;
  logic                 out_ready;
  sfl_pkg::out_item_t   out_next;

  function automatic logic [sfl_pkg::TEX_BITS-1:0] sat_texel(
    input logic [sfl_pkg::QUOT_BITS-1:0] q,
    input logic [sfl_pkg::SIZE_BITS-1:0] size
  );
    logic [sfl_pkg::CAP_BITS-1:0] cap;
    logic [sfl_pkg::CAP_BITS-1:0] qw;
    logic [sfl_pkg::CAP_BITS-1:0] capm1;
    cap   = (sfl_pkg::CAP_BITS'(size) > TEX_LIMIT) ? TEX_LIMIT : sfl_pkg::CAP_BITS'(size);
    qw    = sfl_pkg::CAP_BITS'(q);
    capm1 = cap - sfl_pkg::CAP_BITS'(1);
    if (size == '0) begin
      return '0;
    end else if (qw >= cap) begin
      return capm1[sfl_pkg::TEX_BITS-1:0];
    end else begin
      return qw[sfl_pkg::TEX_BITS-1:0];
    end
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sky_enabled <= 1'b1;
      tex_width   <= sfl_pkg::SIZE_BITS'(256);
      tex_height  <= sfl_pkg::SIZE_BITS'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfl_pkg::CFG_SKY_ENABLED: sky_enabled <= cfg_data[0];
        sfl_pkg::CFG_TEX_WIDTH:   tex_width   <= cfg_data;
        sfl_pkg::CFG_TEX_HEIGHT:  tex_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !fs_ready;

  sfl_face_sel u_face_sel (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .ready       (fs_ready),
    .sky_enabled (sky_enabled),
    .out_valid   (fs_valid),
    .out_data    (fs_data),
    .down_ready  (div_ready)
  );

  sfl_div u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (fs_valid),
    .in_data    (fs_data),
    .ready      (div_ready),
    .tex_width  (tex_width),
    .tex_height (tex_height),
    .out_valid  (div_valid),
    .out_data   (div_data),
    .down_ready (out_ready)
  );

  assign out_ready = !out_valid || !out_stall;

  // Clamp the far edge to min(size, 4096)-1, give 0 for a size of 0, and zero everything on a miss
  always_comb begin
    out_next.hit = div_data.tag.hit;
    if (div_data.tag.hit) begin
      out_next.face    = div_data.tag.face;
      out_next.texel_x = sat_texel(div_data.quot_x, tex_width);
      out_next.texel_y = sat_texel(div_data.quot_y, tex_height);
    end else begin
      out_next.face    = sfl_pkg::FACE_FRONT;
      out_next.texel_x = '0;
      out_next.texel_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= div_valid;
    end
    if (out_ready && div_valid) begin
      out_item <= out_next;
    end
  end

endmodule

`default_nettype wire
